>>> hdl/xmk_pkg.sv
`default_nettype none
package xmk_pkg;

  localparam int unsigned ID_W       = 256;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned EP_W       = 145;  // addr_hi, addr_lo, port, v6
  localparam int unsigned NUM_BKT    = 256;
  localparam int unsigned BKT_W      = 8;
  localparam int unsigned WANT_W     = 6;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  // opcodes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_REFRESHED = 3'd1;
  localparam logic [STAT_W-1:0] ST_SELF      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd5;
  localparam logic [STAT_W-1:0] ST_ENTRY     = 3'd6;
  localparam logic [STAT_W-1:0] ST_NONE      = 3'd7;

  // position of the first set bit counted from the MSB
  function automatic logic [5:0] lead_pos(input logic [WORD_W-1:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) r = 6'(63 - i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/xor_metric_kbucket_table_unit.sv
// Add and remove: busy for the leading-bit search (one 64-bit word a cycle)
//   and the slot scan; the result is registered on the cycle after the scan ends.
// Find: one full table pass per returned item.
// Self-ignored adds and finds with want_count 0 answer in the cycle after start.
// One item at a time. Results are strobed for one cycle; the receiver cannot stall.
// Reset clears control state and all bucket fills; entry storage is not cleared.
`default_nettype none
module xor_metric_kbucket_table_unit
  import xmk_pkg::*;
#(
  parameter int unsigned K_PER_BUCKET = 8,
  parameter int unsigned MAX_RETURN   = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_wdata_i,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [WORD_W-1:0]    id_w0_i,
  input  wire logic [WORD_W-1:0]    id_w1_i,
  input  wire logic [WORD_W-1:0]    id_w2_i,
  input  wire logic [WORD_W-1:0]    id_w3_i,
  input  wire logic                 has_endpoint_i,
  input  wire logic [WORD_W-1:0]    addr_hi_i,
  input  wire logic [WORD_W-1:0]    addr_lo_i,
  input  wire logic [15:0]          endpoint_port_i,
  input  wire logic                 endpoint_v6_i,
  input  wire logic [WANT_W-1:0]    want_count_i,
  output logic                      res_valid_o,
  output logic [STAT_W-1:0]         status_o,
  output logic [WORD_W-1:0]         out_id_w0_o,
  output logic [WORD_W-1:0]         out_id_w1_o,
  output logic [WORD_W-1:0]         out_id_w2_o,
  output logic [WORD_W-1:0]         out_id_w3_o,
  output logic [WORD_W-1:0]         out_addr_hi_o,
  output logic [WORD_W-1:0]         out_addr_lo_o,
  output logic [15:0]               out_port_o,
  output logic                      out_v6_o,
  output logic                      is_last_o
);

  localparam int unsigned SLOTS = NUM_BKT * K_PER_BUCKET;
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned FW    = $clog2(K_PER_BUCKET + 1);
  localparam logic [FW-1:0] K_FILL = FW'(K_PER_BUCKET);
  localparam logic [WANT_W-1:0] MAX_RET = WANT_W'(MAX_RETURN);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LEAD  = 4'd1;
  localparam logic [3:0] S_FRD   = 4'd2;
  localparam logic [3:0] S_FWT   = 4'd3;
  localparam logic [3:0] S_SCMP  = 4'd4;
  localparam logic [3:0] S_MISS  = 4'd5;
  localparam logic [3:0] S_CPY   = 4'd6;
  localparam logic [3:0] S_FFWT  = 4'd7;
  localparam logic [3:0] S_FCMP  = 4'd8;
  localparam logic [3:0] S_FPEND = 4'd9;
  localparam logic [3:0] S_FGET  = 4'd10;
  localparam logic [3:0] S_FLAST = 4'd11;

  logic [3:0]        state_q, state_d;
  logic [ID_W-1:0]   self_q;
  logic [1:0]        op_q;
  logic [ID_W-1:0]   id_q;
  logic              hasep_q;
  logic [EP_W-1:0]   ep_q;
  logic [WANT_W-1:0] want_q;
  logic [1:0]        wcnt_q;
  logic [BKT_W-1:0]  bk_q;
  logic [FW-1:0]     s_q;
  logic [FW-1:0]     fill_q;
  logic [WANT_W-1:0] n_q;
  logic              found_q, prev_vld_q;
  logic [ID_W-1:0]   best_d_q, prev_d_q;
  logic [AW-1:0]     best_p_q, prev_p_q;
  logic [ID_W-1:0]   pend_id_q;
  logic [EP_W-1:0]   pend_ep_q;

  // entry storage
  logic [ID_W-1:0] idm [SLOTS];
  logic [EP_W-1:0] epm [SLOTS];
  logic [ID_W-1:0] idm_rd_q;
  logic [EP_W-1:0] epm_rd_q;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            idm_we, epm_we;
  logic [ID_W-1:0] idm_wd;
  logic [EP_W-1:0] epm_wd;

  // fill table port
  logic [BKT_W-1:0] fill_ra;
  logic [FW-1:0]    fill_rd;
  logic             fill_we;
  logic [FW-1:0]    fill_wd;

  // result strobe
  logic              emit, emit_entry, emit_last;
  logic [STAT_W-1:0] emit_st;

  logic              accept;
  logic [ID_W-1:0]   id_in;
  logic [WANT_W-1:0] want_in;
  logic [WORD_W-1:0] dword;
  logic [ID_W-1:0]   id_dist;
  logic              hit, ok_prev, better, more_slots, last_bkt;
  logic [AW-1:0]     base, cur_p;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign id_in   = {id_w0_i, id_w1_i, id_w2_i, id_w3_i};
  assign want_in = (want_count_i > MAX_RET) ? MAX_RET : want_count_i;
  assign id_dist = id_q ^ self_q;
  assign dword   = id_dist[ID_W-1 - 64*wcnt_q -: WORD_W];

  assign base       = AW'(bk_q) * AW'(K_PER_BUCKET);
  assign cur_p      = base + AW'(s_q);
  assign hit        = (idm_rd_q == id_q);
  assign more_slots = ((s_q + FW'(1)) < fill_q);
  assign last_bkt   = (bk_q == BKT_W'(NUM_BKT - 1));

  // find ordering: after previous pick, before current best
  always_comb begin
    logic [ID_W-1:0] d;
    d       = idm_rd_q ^ id_q;
    ok_prev = !prev_vld_q || (d > prev_d_q) || ((d == prev_d_q) && (cur_p > prev_p_q));
    better  = !found_q || (d < best_d_q);
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q <= '0;
    end else if (cfg_we_i) begin
      self_q[ID_W-1 - 64*cfg_idx_i -: WORD_W] <= cfg_wdata_i;
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    emit       = 1'b0;
    emit_entry = 1'b0;
    emit_last  = 1'b1;
    emit_st    = ST_NONE;
    idm_we     = 1'b0;
    epm_we     = 1'b0;
    idm_wd     = id_q;
    epm_wd     = ep_q;
    wr_addr    = base + AW'(fill_q);
    rd_addr    = cur_p;
    fill_we    = 1'b0;
    fill_wd    = fill_q + FW'(1);
    fill_ra    = (state_q == S_FRD) ? bk_q : bk_q + BKT_W'(1);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (opcode_i == OP_ADD && id_in == self_q) begin
            emit    = 1'b1;
            emit_st = ST_SELF;
          end else if (opcode_i == OP_ADD || opcode_i == OP_REMOVE) begin
            state_d = S_LEAD;
          end else if (opcode_i == OP_FIND) begin
            if (want_in == '0) begin
              emit    = 1'b1;
              emit_st = ST_NONE;
            end else begin
              state_d = S_FRD;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_LEAD: if (dword != '0 || wcnt_q == 2'd3) state_d = S_FRD;
      S_FRD:  state_d = (op_q == OP_FIND) ? S_FFWT : S_FWT;
      S_FWT: begin
        rd_addr = base;
        state_d = (fill_rd == '0) ? S_MISS : S_SCMP;
      end
      S_SCMP: begin
        rd_addr = cur_p + AW'(1);
        if (hit) begin
          if (op_q == OP_ADD) begin
            epm_we  = hasep_q;
            wr_addr = cur_p;
            emit    = 1'b1;
            emit_st = ST_REFRESHED;
            state_d = S_IDLE;
          end else begin
            rd_addr = base + AW'(fill_q - FW'(1));
            state_d = S_CPY;
          end
        end else if (!more_slots) begin
          state_d = S_MISS;
        end
      end
      S_MISS: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        if (op_q == OP_REMOVE) begin
          emit_st = ST_ABSENT;
        end else if (fill_q >= K_FILL) begin
          emit_st = ST_FULL;
        end else begin
          idm_we  = 1'b1;
          epm_we  = 1'b1;
          fill_we = 1'b1;
          emit_st = ST_ADDED;
        end
      end
      S_CPY: begin
        idm_we  = 1'b1;
        epm_we  = 1'b1;
        idm_wd  = idm_rd_q;
        epm_wd  = epm_rd_q;
        wr_addr = cur_p;
        fill_we = 1'b1;
        fill_wd = fill_q - FW'(1);
        emit    = 1'b1;
        emit_st = ST_REMOVED;
        state_d = S_IDLE;
      end
      S_FFWT: begin
        rd_addr = base;
        if (fill_rd != '0) state_d = S_FCMP;
        else if (last_bkt) state_d = S_FPEND;
      end
      S_FCMP: begin
        rd_addr = cur_p + AW'(1);
        if (!more_slots) state_d = last_bkt ? S_FPEND : S_FFWT;
      end
      S_FPEND: begin
        rd_addr = best_p_q;
        if (found_q) begin
          state_d = S_FGET;
        end else begin
          emit       = 1'b1;
          emit_entry = (n_q != '0);
          emit_st    = (n_q != '0) ? ST_ENTRY : ST_NONE;
          state_d    = S_IDLE;
        end
      end
      S_FGET: begin
        emit       = (n_q != '0);
        emit_entry = 1'b1;
        emit_last  = 1'b0;
        emit_st    = ST_ENTRY;
        state_d    = ((n_q + WANT_W'(1)) == want_q) ? S_FLAST : S_FRD;
      end
      S_FLAST: begin
        emit       = 1'b1;
        emit_entry = 1'b1;
        emit_st    = ST_ENTRY;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_o <= emit;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q       <= opcode_i;
        id_q       <= id_in;
        hasep_q    <= has_endpoint_i;
        ep_q       <= has_endpoint_i ?
                      {addr_hi_i, addr_lo_i, endpoint_port_i, endpoint_v6_i} : '0;
        want_q     <= want_in;
        wcnt_q     <= '0;
        bk_q       <= '0;
        n_q        <= '0;
        found_q    <= 1'b0;
        prev_vld_q <= 1'b0;
      end
      S_LEAD: begin
        wcnt_q <= wcnt_q + 2'd1;
        if (dword != '0) bk_q <= {wcnt_q, lead_pos(dword)};
        else             bk_q <= '0;
      end
      S_FWT: begin
        fill_q <= fill_rd;
        s_q    <= '0;
      end
      S_SCMP: if (!hit) s_q <= s_q + FW'(1);
      S_FFWT: begin
        fill_q <= fill_rd;
        s_q    <= '0;
        if (fill_rd == '0 && !last_bkt) bk_q <= bk_q + BKT_W'(1);
      end
      S_FCMP: begin
        if (ok_prev && better) begin
          found_q  <= 1'b1;
          best_d_q <= idm_rd_q ^ id_q;
          best_p_q <= cur_p;
        end
        if (more_slots) s_q <= s_q + FW'(1);
        else if (!last_bkt) bk_q <= bk_q + BKT_W'(1);
      end
      S_FGET: begin
        pend_id_q  <= idm_rd_q;
        pend_ep_q  <= epm_rd_q;
        prev_d_q   <= best_d_q;
        prev_p_q   <= best_p_q;
        prev_vld_q <= 1'b1;
        n_q        <= n_q + WANT_W'(1);
        found_q    <= 1'b0;
        bk_q       <= '0;
      end
      default: ;
    endcase
  end

  // entry memories
  always_ff @(posedge clk_i) begin
    if (idm_we) idm[wr_addr] <= idm_wd;
    if (epm_we) epm[wr_addr] <= epm_wd;
    idm_rd_q <= idm[rd_addr];
    epm_rd_q <= epm[rd_addr];
  end

  xmk_fill_table #(.FW(FW)) u_fill (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (fill_ra),
    .rd_data_o (fill_rd),
    .we_i      (fill_we),
    .wr_addr_i (bk_q),
    .wr_data_i (fill_wd)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_o <= emit_st;
      is_last_o <= emit_last;
      if (emit_entry) begin
        {out_id_w0_o, out_id_w1_o, out_id_w2_o, out_id_w3_o} <= pend_id_q;
        {out_addr_hi_o, out_addr_lo_o, out_port_o, out_v6_o} <= pend_ep_q;
      end else begin
        {out_id_w0_o, out_id_w1_o, out_id_w2_o, out_id_w3_o} <= '0;
        {out_addr_hi_o, out_addr_lo_o, out_port_o, out_v6_o} <= '0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/xmk_fill_table.sv
`default_nettype none
// Per-bucket fill counts; valid bits make unwritten buckets read as zero.
module xmk_fill_table
  import xmk_pkg::*;
#(
  parameter int unsigned FW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [BKT_W-1:0] rd_addr_i,
  output logic      [FW-1:0]    rd_data_o,
  input  wire logic             we_i,
  input  wire logic [BKT_W-1:0] wr_addr_i,
  input  wire logic [FW-1:0]    wr_data_i
);

  logic [FW-1:0]      mem [NUM_BKT];
  logic [NUM_BKT-1:0] vld_q;
  logic [FW-1:0]      rd_q;
  logic               rdv_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (we_i) mem[wr_addr_i] <= wr_data_i;
    rd_q <= mem[rd_addr_i];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      if (we_i) vld_q[wr_addr_i] <= 1'b1;
      rdv_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rdv_q ? rd_q : '0;

endmodule
`default_nettype wire

>>> hdl/xmk_checker.sv
`default_nettype none
module xmk_checker
  import xmk_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [1:0]        opcode_i,
  input wire logic              res_valid_o,
  input wire logic [STAT_W-1:0] status_o,
  input wire logic [WORD_W-1:0] out_id_w0_o,
  input wire logic [15:0]       out_port_o,
  input wire logic              is_last_o
);

  // non-entry results are always final
  a_stat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != ST_ENTRY |-> is_last_o)
    else $error("status item without last flag");

  // non-entry results carry zero entry fields
  a_stat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != ST_ENTRY |-> out_id_w0_o == '0 && out_port_o == '0)
    else $error("status item with entry data");

  // an accepted remove always makes the unit busy
  a_rm_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && opcode_i == OP_REMOVE |=> busy)
    else $error("remove did not start");

  // no result appears right after an idle cycle without a start
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !res_valid_o)
    else $error("result without item");

endmodule

bind xor_metric_kbucket_table_unit xmk_checker u_xmk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .opcode_i    (opcode_i),
  .res_valid_o (res_valid_o),
  .status_o    (status_o),
  .out_id_w0_o (out_id_w0_o),
  .out_port_o  (out_port_o),
  .is_last_o   (is_last_o)
);
`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none
module testbench;
  import xmk_pkg::*;

  localparam int unsigned KB = 8;
  localparam int unsigned MAXRET = 32;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [255:0]      id;
    logic [63:0]       addr_hi;
    logic [63:0]       addr_lo;
    logic [15:0]       port;
    logic              v6;
    logic              last;
  } reply_t;

  typedef struct {
    logic [1:0]   op;
    logic [255:0] id;
    logic         has_ep;
    logic [63:0]  addr_hi;
    logic [63:0]  addr_lo;
    logic [15:0]  port;
    logic         v6;
    logic [5:0]   want;
  } req_t;

  // Shadow routing table and the queue of replies it predicts
  class table_scoreboard;
    logic [255:0] own_id;
    int           fill[NUM_BKT];
    logic [255:0] ids[NUM_BKT*KB];
    logic [63:0]  ahi[NUM_BKT*KB];
    logic [63:0]  alo[NUM_BKT*KB];
    logic [15:0]  prt[NUM_BKT*KB];
    logic         v6s[NUM_BKT*KB];
    reply_t       pending[$];
    int           errors;

    function new();
      own_id = '0;
      errors = 0;
      foreach (fill[b]) fill[b] = 0;
    endfunction

    function int bucket_of(logic [255:0] id);
      logic [255:0] d;
      d = id ^ own_id;
      for (int i = 0; i < 256; i++) if (d[255-i]) return i;
      return 0;
    endfunction

    function void push_status(logic [STAT_W-1:0] st);
      reply_t r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      pending.push_back(r);
    endfunction

    function void note_request(req_t q);
      int bk, p, n, want, bestp, prevp;
      logic [255:0] d, bestd, prevd;
      bit found, havep;
      reply_t r;
      if (q.op == OP_ADD) begin
        if (q.id == own_id) begin push_status(ST_SELF); return; end
        bk = bucket_of(q.id);
        for (int s = 0; s < fill[bk]; s++) begin
          p = bk*KB + s;
          if (ids[p] == q.id) begin
            if (q.has_ep) begin
              ahi[p] = q.addr_hi; alo[p] = q.addr_lo; prt[p] = q.port; v6s[p] = q.v6;
            end
            push_status(ST_REFRESHED);
            return;
          end
        end
        if (fill[bk] >= KB) begin push_status(ST_FULL); return; end
        p = bk*KB + fill[bk];
        ids[p] = q.id;
        ahi[p] = q.has_ep ? q.addr_hi : '0;
        alo[p] = q.has_ep ? q.addr_lo : '0;
        prt[p] = q.has_ep ? q.port : '0;
        v6s[p] = q.has_ep ? q.v6 : 1'b0;
        fill[bk]++;
        push_status(ST_ADDED);
      end else if (q.op == OP_REMOVE) begin
        bk = bucket_of(q.id);
        for (int s = 0; s < fill[bk]; s++) begin
          p = bk*KB + s;
          if (ids[p] == q.id) begin
            n = bk*KB + fill[bk] - 1;
            ids[p] = ids[n]; ahi[p] = ahi[n]; alo[p] = alo[n];
            prt[p] = prt[n]; v6s[p] = v6s[n];
            fill[bk]--;
            push_status(ST_REMOVED);
            return;
          end
        end
        push_status(ST_ABSENT);
      end else if (q.op == OP_FIND) begin
        want = (q.want > MAXRET) ? MAXRET : q.want;
        n = 0; havep = 0; prevd = '0; prevp = 0;
        while (n < want) begin
          found = 0; bestd = '0; bestp = 0;
          for (int b = 0; b < NUM_BKT; b++) begin
            for (int s = 0; s < fill[b]; s++) begin
              p = b*KB + s;
              d = ids[p] ^ q.id;
              if (havep && (d < prevd || (d == prevd && p <= prevp))) continue;
              if (found && (d > bestd || (d == bestd && p >= bestp))) continue;
              bestd = d; bestp = p; found = 1;
            end
          end
          if (!found) break;
          r = '0;
          r.status = ST_ENTRY;
          r.id = ids[bestp]; r.addr_hi = ahi[bestp]; r.addr_lo = alo[bestp];
          r.port = prt[bestp]; r.v6 = v6s[bestp];
          pending.push_back(r);
          prevd = bestd; prevp = bestp; havep = 1;
          n++;
        end
        if (n == 0) push_status(ST_NONE);
        else pending[pending.size()-1].last = 1'b1;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item, status %0d", got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, got.status); errors++;
      end
      if (got.id[255:192] !== e.id[255:192]) begin
        $error("out_id_w0: expected %h actual %h", e.id[255:192], got.id[255:192]);
        errors++;
      end
      if (got.id[191:128] !== e.id[191:128]) begin
        $error("out_id_w1: expected %h actual %h", e.id[191:128], got.id[191:128]);
        errors++;
      end
      if (got.id[127:64] !== e.id[127:64]) begin
        $error("out_id_w2: expected %h actual %h", e.id[127:64], got.id[127:64]);
        errors++;
      end
      if (got.id[63:0] !== e.id[63:0]) begin
        $error("out_id_w3: expected %h actual %h", e.id[63:0], got.id[63:0]);
        errors++;
      end
      if (got.addr_hi !== e.addr_hi) begin
        $error("out_addr_hi: expected %h actual %h", e.addr_hi, got.addr_hi); errors++;
      end
      if (got.addr_lo !== e.addr_lo) begin
        $error("out_addr_lo: expected %h actual %h", e.addr_lo, got.addr_lo); errors++;
      end
      if (got.port !== e.port) begin
        $error("out_port: expected %h actual %h", e.port, got.port); errors++;
      end
      if (got.v6 !== e.v6) begin
        $error("out_v6: expected %b actual %b", e.v6, got.v6); errors++;
      end
      if (got.last !== e.last) begin
        $error("is_last: expected %b actual %b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WORD_W-1:0] cfg_wdata;
  logic start, busy;
  logic [1:0] opcode;
  logic [63:0] id_w0, id_w1, id_w2, id_w3, addr_hi, addr_lo;
  logic has_ep, ep_v6;
  logic [15:0] ep_port;
  logic [WANT_W-1:0] want;
  logic res_valid;
  logic [STAT_W-1:0] status;
  logic [63:0] o_id0, o_id1, o_id2, o_id3, o_ahi, o_alo;
  logic [15:0] o_port;
  logic o_v6, o_last;

  table_scoreboard sb;
  logic [255:0] recent[$];
  bit calm;

  xor_metric_kbucket_table_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .start(start), .busy(busy),
    .opcode_i(opcode), .id_w0_i(id_w0), .id_w1_i(id_w1), .id_w2_i(id_w2),
    .id_w3_i(id_w3), .has_endpoint_i(has_ep), .addr_hi_i(addr_hi),
    .addr_lo_i(addr_lo), .endpoint_port_i(ep_port), .endpoint_v6_i(ep_v6),
    .want_count_i(want),
    .res_valid_o(res_valid), .status_o(status),
    .out_id_w0_o(o_id0), .out_id_w1_o(o_id1), .out_id_w2_o(o_id2),
    .out_id_w3_o(o_id3), .out_addr_hi_o(o_ahi), .out_addr_lo_o(o_alo),
    .out_port_o(o_port), .out_v6_o(o_v6), .is_last_o(o_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("xor_metric_kbucket_table_unit regression: fail");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && res_valid === 1'b1)
      sb.check_reply({status, o_id0, o_id1, o_id2, o_id3, o_ahi, o_alo, o_port, o_v6,
                      o_last});
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one register write; the caller drops the write enable after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.own_id[255 - 64*idx -: 64] = val;
  endtask

  task automatic set_own_id(input logic [255:0] v);
    for (int i = 0; i < 4; i++) write_reg(CFG_IDX_W'(i), v[255 - 64*i -: 64]);
    cfg_we <= 1'b0;
  endtask

  // wait for all predicted replies, then a guard for trailing activity
  task automatic drain();
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic issue(input req_t q);
    if (!calm && $urandom_range(99) < 9) repeat ($urandom_range(1, 5)) @(posedge clk);
    start <= 1'b1;
    opcode <= q.op;
    {id_w0, id_w1, id_w2, id_w3} <= q.id;
    has_ep <= q.has_ep; addr_hi <= q.addr_hi; addr_lo <= q.addr_lo;
    ep_port <= q.port; ep_v6 <= q.v6; want <= q.want;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(q);
    start <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic req_t rand_req(input logic [1:0] op);
    req_t q;
    q.op = op;
    q.id = {rand64(), rand64(), rand64(), rand64()};
    q.has_ep = 1'($urandom_range(1));
    q.addr_hi = rand64(); q.addr_lo = rand64();
    q.port = 16'($urandom()); q.v6 = 1'($urandom_range(1));
    q.want = 6'($urandom_range(0, 63));
    return q;
  endfunction

  // ID near own ID so that a few buckets fill up
  function automatic logic [255:0] near_id();
    logic [255:0] v;
    if (recent.size() > 0 && $urandom_range(99) < 40)
      return recent[$urandom_range(recent.size()-1)];
    v = sb.own_id ^ (256'(1) << $urandom_range(255, 250));
    v[3:0] = 4'($urandom());
    return v;
  endfunction

  initial begin
    req_t q;
    int r;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    start = 1'b0; opcode = OP_ADD;
    {id_w0, id_w1, id_w2, id_w3} = '0;
    has_ep = 1'b0; addr_hi = '0; addr_lo = '0; ep_port = '0; ep_v6 = 1'b0; want = '0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, self, extremes
    set_own_id('0);
    q = rand_req(OP_FIND); q.want = 5; issue(q);
    q = rand_req(OP_ADD); q.id = '0; issue(q);
    q = rand_req(OP_REMOVE); q.id = '0; issue(q);
    q = rand_req(OP_ADD); q.id = '1; q.has_ep = 1; q.addr_hi = '1; q.addr_lo = '1;
    q.port = '1; q.v6 = 1; issue(q);
    q.has_ep = 0; issue(q);
    q.has_ep = 1; q.addr_hi = '0; q.addr_lo = '0; q.port = '0; q.v6 = 0; issue(q);
    q = rand_req(OP_ADD); q.id = 256'd1; q.has_ep = 0; issue(q);
    for (int i = 0; i < 9; i++) begin
      q = rand_req(OP_ADD); q.id = {1'b1, 251'd0, 4'(i)}; issue(q);
    end
    q = rand_req(OP_FIND); q.id = '0; q.want = 0; issue(q);
    q.want = 63; issue(q);
    q.want = 3; q.id = '1; issue(q);
    q = rand_req(OP_REMOVE); q.id = {1'b1, 251'd0, 4'd0}; issue(q);
    q.id = {1'b1, 251'd0, 4'd15}; issue(q);
    q = rand_req(2'd3); issue(q);
    drain();

    // random phases under several own IDs
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_own_id('1);
        1: set_own_id({rand64(), rand64(), rand64(), rand64()});
        2: set_own_id('0);
        default: set_own_id({rand64(), rand64(), rand64(), rand64()});
      endcase
      recent.delete();
      calm = (ph == 2);
      for (int n = 0; n < 20; n++) begin
        r = $urandom_range(99);
        if (r < 50) begin
          q = rand_req(OP_ADD);
          if ($urandom_range(99) < 80) q.id = near_id();
          if ($urandom_range(99) < 3) q.id = sb.own_id;
          recent.push_back(q.id);
        end else if (r < 78) begin
          q = rand_req(OP_REMOVE);
          if ($urandom_range(99) < 70) q.id = near_id();
        end else if (r < 96) begin
          q = rand_req(OP_FIND);
          q.want = ($urandom_range(99) < 70) ? 6'($urandom_range(0, 10))
                                             : 6'($urandom_range(0, 63));
          if ($urandom_range(1)) q.id = near_id();
        end else begin
          q = rand_req(2'd3);
        end
        issue(q);
      end
      drain();
    end

    if (sb.pending.size() != 0) begin
      $error("%0d expected result items never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("xor_metric_kbucket_table_unit regression: pass");
    end else begin
      $display("xor_metric_kbucket_table_unit regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
